// File: rtl/dgcd_pkg.sv
// Shared request and status codes for the directed graph cycle detector.
`timescale 1ns / 1ps
package dgcd_pkg;

  localparam int REQ_W    = 2;
  localparam int VERT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int TOTAL_W  = 9;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

endpackage

// File: rtl/dgcd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module dgcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/directed_graph_cycle_detector_core.sv
// Top level: adjacency matrix in RAM, arc updates and peeling cycle search.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------------
//   in       | input     | in_valid / in_stall   | req_type, from_vertex, to_vertex
//   out      | output    | out_valid / out_stall | status, arc_total, cycle_found
//   cfg      | input     | cfg_wr_en            | cfg_wr_data (vertex_count)
//
// One item at a time. Accept, then a read-modify-write in S_MODIFY for an in-range arc,
// then the peeling search: P passes, one adjacency row read per cycle from the single RAM
// read port, with P <= n and n the vertex count in use; then S_FIN hands the result to the
// output register, waiting while a held result is stalled. Reset clears the matrix at once
// through per-row valid bits. A stalled result holds in the output register while the next
// item is taken.
`timescale 1ns / 1ps
module directed_graph_cycle_detector_core
  import dgcd_pkg::*;
#(
  parameter int MAX_VERTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [VERT_W-1:0]  from_vertex,
  input  logic [VERT_W-1:0]  to_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic [TOTAL_W-1:0] arc_total,
  output logic               cycle_found
);

  localparam int AW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MODIFY = 3'd1;
  localparam logic [2:0] S_PEEL   = 3'd2;
  localparam logic [2:0] S_FIN    = 3'd3;

  logic [2:0]           state;
  logic [COUNT_W-1:0]   vertex_count;
  logic [TOTAL_W-1:0]   arc_cnt;
  logic [MAX_VERTS-1:0] row_valid;
  logic                 rd_ok;
  logic [REQ_W-1:0]     req_kind;
  logic [AW-1:0]        req_from;
  logic [VERT_W-1:0]    req_to;
  logic                 req_status;
  logic [MAX_VERTS-1:0] alive;
  logic                 changed;
  logic [CW-1:0]        iss_cnt;
  logic                 pend;
  logic [AW-1:0]        pend_idx;
  logic                 res_cycle;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [MAX_VERTS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [MAX_VERTS-1:0] ram_rdata;

  logic [CW-1:0]        n_eff;
  logic [MAX_VERTS-1:0] init_alive;
  logic [MAX_VERTS-1:0] rd_row;
  logic [MAX_VERTS-1:0] arc_bit;
  logic                 present;
  logic                 accept;
  logic                 arc_req;
  logic                 in_range;
  logic                 in_write;
  logic                 in_bad;
  logic                 issuing;
  logic                 pend_hit;
  logic                 drained;
  logic                 out_free;

  dgcd_ram #(
    .WIDTH(MAX_VERTS),
    .DEPTH(MAX_VERTS)
  ) u_adj_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (int'(vertex_count) > MAX_VERTS) begin
      n_eff = CW'(MAX_VERTS);
    end else begin
      n_eff = CW'(vertex_count);
    end
    for (int v = 0; v < MAX_VERTS; v++) begin
      init_alive[v] = (v < int'(n_eff));
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign arc_req  = (req_type == REQ_INSERT) || (req_type == REQ_REMOVE);
  assign in_range = (int'(from_vertex) < int'(n_eff)) && (int'(to_vertex) < int'(n_eff));
  assign in_write = arc_req && in_range;
  assign in_bad   = (arc_req && !in_range) || (req_type == REQ_UNUSED);

  assign rd_row   = rd_ok ? ram_rdata : '0;
  assign arc_bit  = MAX_VERTS'(1) << req_to;
  assign present  = |(rd_row & arc_bit);
  assign issuing  = (iss_cnt < n_eff);
  assign pend_hit = pend && alive[pend_idx] && ((rd_row & alive) == '0);
  assign drained  = !issuing && !pend;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = req_from;
    ram_wdata = rd_row;
    unique case (state)
      S_IDLE: begin
        ram_re    = in_valid;
        ram_raddr = AW'(from_vertex);
      end
      S_MODIFY: begin
        if (req_kind == REQ_INSERT && !present) begin
          ram_we    = 1'b1;
          ram_wdata = rd_row | arc_bit;
        end else if (req_kind == REQ_REMOVE && present) begin
          ram_we    = 1'b1;
          ram_wdata = rd_row & ~arc_bit;
        end
      end
      S_PEEL: begin
        ram_re    = issuing;
        ram_raddr = iss_cnt[AW-1:0];
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_ok <= row_valid[ram_raddr];
    end
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= VERTEX_COUNT_RESET;
      arc_cnt      <= '0;
      row_valid    <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_kind   <= req_type;
            req_from   <= AW'(from_vertex);
            req_to     <= to_vertex;
            req_status <= in_bad ? STATUS_REJECT : STATUS_OK;
            alive      <= init_alive;
            changed    <= 1'b0;
            iss_cnt    <= '0;
            pend       <= 1'b0;
            state      <= in_write ? S_MODIFY : S_PEEL;
          end
        end
        S_MODIFY: begin
          if (ram_we) begin
            row_valid[req_from] <= 1'b1;
            if (req_kind == REQ_INSERT) begin
              arc_cnt <= arc_cnt + 1'b1;
            end else begin
              arc_cnt <= arc_cnt - 1'b1;
            end
          end
          state <= S_PEEL;
        end
        S_PEEL: begin
          if (pend_hit) begin
            alive[pend_idx] <= 1'b0;
            changed         <= 1'b1;
          end
          if (issuing) begin
            iss_cnt  <= iss_cnt + 1'b1;
            pend     <= 1'b1;
            pend_idx <= iss_cnt[AW-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (drained) begin
            if (changed && (alive != '0)) begin
              iss_cnt <= '0;
              changed <= 1'b0;
            end else begin
              res_cycle <= |alive;
              state     <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= req_status;
            arc_total   <= arc_cnt;
            cycle_found <= res_cycle;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/dgcd_checker.sv
// Port-level checks for the cycle detector, bound to the top level.
`timescale 1ns / 1ps
module dgcd_checker
  import dgcd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               status,
  input logic [TOTAL_W-1:0] arc_total,
  input logic               cycle_found
);

  logic               have_last;
  logic [TOTAL_W-1:0] last_total;
  logic               out_beat;

  assign out_beat = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
    end else begin
      if (out_beat) begin
        have_last  <= 1'b1;
        last_total <= arc_total;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(arc_total)
      && $stable(cycle_found))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  a_step: assert property (@(posedge clk) disable iff (rst)
    out_beat && have_last |-> arc_total == last_total
      || arc_total == last_total + 1'b1 || arc_total == last_total - 1'b1)
    else $error("arc total moved by more than one");

  a_keep: assert property (@(posedge clk) disable iff (rst)
    out_beat && have_last && (status == STATUS_REJECT) |-> arc_total == last_total)
    else $error("arc total changed on a rejected item");

endmodule

bind directed_graph_cycle_detector_core dgcd_checker u_dgcd_checker (.*);
